// ----- hdl/rwn_pkg.sv -----
// Shared constants for the row Euclidean norm block.
package rwn_pkg;

  localparam int ELEM_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 48;
  localparam int LEN_WIDTH      = 24;

endpackage

// ----- hdl/rwn_front.sv -----
// Front end: square each element and accumulate the row's sum of squares.
module rwn_front #(
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ELEM_WIDTH-1:0] element,
  input  logic                 last_in_row,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [ACC_WIDTH:0]   push_data
);

  localparam int SQ_W  = 2 * ELEM_WIDTH;
  localparam int SUM_W = ((ACC_WIDTH > SQ_W) ? ACC_WIDTH : SQ_W) + 1;

  logic [ELEM_WIDTH-1:0] mag;
  logic                  sq_valid;
  logic                  sq_last;
  logic [SQ_W-1:0]       sq;
  logic [ACC_WIDTH-1:0]  square_sum;
  logic                  overflowed;
  logic                  advance;
  logic [SUM_W-1:0]      sum_wide;
  logic                  sum_ovf;
  logic [ACC_WIDTH-1:0]  sum_next;
  logic                  overflowed_next;

  // Magnitude of the most negative code wraps to 2^(ELEM_WIDTH-1), read unsigned.
  assign mag = element[ELEM_WIDTH-1] ? (~element + ELEM_WIDTH'(1)) : element;

  assign advance  = sq_valid && (!sq_last || push_ready);
  assign in_ready = !sq_valid || advance;

  assign sum_wide = SUM_W'(square_sum) + SUM_W'(sq);
  assign sum_ovf  = (sum_wide >> ACC_WIDTH) != '0;
  assign sum_next = sum_ovf ? '1 : sum_wide[ACC_WIDTH-1:0];
  assign overflowed_next = overflowed | sum_ovf;

  assign push_valid = sq_valid && sq_last;
  assign push_data  = {overflowed_next, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid   <= 1'b0;
      square_sum <= '0;
      overflowed <= 1'b0;
    end else begin
      if (in_ready) begin
        sq_valid <= in_valid;
      end
      if (advance) begin
        // Clear the sum at the row end; the finished sum goes to the queue.
        if (sq_last) begin
          square_sum <= '0;
          overflowed <= 1'b0;
        end else begin
          square_sum <= sum_next;
          overflowed <= overflowed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq      <= SQ_W'(mag) * SQ_W'(mag);
      sq_last <= last_in_row;
    end
  end

endmodule

// ----- hdl/rwn_queue.sv -----
// Two-entry queue between the accumulator and the square-root unit.
module rwn_queue #(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/rwn_sqrt.sv -----
// Back end: bit-serial floor sqrt, one root bit per unstalled cycle, result register.
module rwn_sqrt #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [ACC_WIDTH:0]           pop_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [rwn_pkg::LEN_WIDTH-1:0] row_length,
  output logic                         saturated
);
  import rwn_pkg::*;

  localparam int NBITS = (ACC_WIDTH + 1) / 2;
  localparam int RW    = 2 * NBITS;
  localparam int REM_W = NBITS + 2;
  localparam int CW    = $clog2(NBITS);
  localparam int RXW   = (NBITS > LEN_WIDTH) ? NBITS : LEN_WIDTH;

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [RW-1:0]    val;
  logic [REM_W-1:0] rem;
  logic [NBITS-1:0] root;
  logic             ovf;
  logic [REM_W-1:0] rem_t;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic [NBITS-1:0] root_n;
  logic             last_step;
  logic             out_free;
  logic [RXW:0]     root_ext;
  logic             too_wide;

  // Bring down two bits, try subtracting 4*root+1.
  assign rem_t  = {rem[REM_W-3:0], val[RW-1:RW-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_t >= trial;
  assign root_n = {root[NBITS-2:0], ge};

  assign last_step = cnt == CW'(NBITS - 1);
  assign out_free  = !res_valid || res_ready;
  assign pop_ready = !busy;

  assign root_ext = (RXW + 1)'(root_n);
  assign too_wide = root_ext[RXW:LEN_WIDTH] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (busy && last_step && out_free) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end else begin
        if (res_ready) begin
          res_valid <= 1'b0;
        end
        if (!busy) begin
          busy <= pop_valid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      val  <= RW'(pop_data[ACC_WIDTH-1:0]);
      ovf  <= pop_data[ACC_WIDTH];
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (!last_step) begin
      val  <= {val[RW-3:0], 2'b00};
      rem  <= ge ? (rem_t - trial) : rem_t;
      root <= root_n;
      cnt  <= cnt + CW'(1);
    end else if (out_free) begin
      row_length <= too_wide ? '1 : root_ext[LEN_WIDTH-1:0];
      saturated  <= ovf | too_wide;
    end
  end

endmodule

// ----- hdl/row_euclidean_norm.sv -----
// Top level of the row Euclidean norm block.
//
// Slave stream: one matrix element per beat. s_tdata carries the signed
// element (two's complement, low ELEM_WIDTH bits, zero padded to bytes);
// s_tlast marks the last element of a row.
// Master stream: one beat per row. m_tdata[23:0] is floor(sqrt(sum of
// squares of the row)); m_tuser[0] is set when the sum clamped at
// 2^ACC_WIDTH-1 or the length clamped at 2^24-1.
// Elements are taken one per cycle while s_tready is high. The front
// squares each element and adds it into the row accumulator; a finished
// row sum enters a two-entry queue. The back computes the root one bit
// per cycle and takes a new row sum only when the last one has gone to
// the result register, so short rows can make the queue fill and
// s_tready drop. Reset (rst, synchronous) clears the accumulator, the
// queue and both valids. When the receiver stalls, the result register
// holds its beat, the root unit holds its final step, the queue fills,
// and then the front drops s_tready.
module row_euclidean_norm #(
  parameter int ELEM_WIDTH = rwn_pkg::ELEM_WIDTH_DEF,
  parameter int ACC_WIDTH  = rwn_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // element
  input  logic                                 s_tlast,   // last_in_row
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rwn_pkg::LEN_WIDTH-1:0]        m_tdata,   // row_length
  output logic [0:0]                           m_tuser    // saturated
);
  import rwn_pkg::*;

  logic               q_wr_valid;
  logic               q_wr_ready;
  logic [ACC_WIDTH:0] q_wr_data;
  logic               q_rd_valid;
  logic               q_rd_ready;
  logic [ACC_WIDTH:0] q_rd_data;

  // Square and accumulate; hand each row sum plus its clamp flag onward.
  rwn_front #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .element     (s_tdata[ELEM_WIDTH-1:0]),
    .last_in_row (s_tlast),
    .push_valid  (q_wr_valid),
    .push_ready  (q_wr_ready),
    .push_data   (q_wr_data)
  );

  // Decouple the element stream from the multi-cycle root.
  rwn_queue #(
    .WIDTH (ACC_WIDTH + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  rwn_sqrt #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_rd_valid),
    .pop_ready  (q_rd_ready),
    .pop_data   (q_rd_data),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .row_length (m_tdata),
    .saturated  (m_tuser[0])
  );

endmodule

// ----- hdl/rwn_checker.sv -----
// Port-level checks for the row Euclidean norm block, bound to the top level.
module rwn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic [3:0] pending;
  logic       row_in;
  logic       row_out;

  assign row_in  = s_tvalid && s_tready && s_tlast;
  assign row_out = m_tvalid && m_tready;

  // Track rows ended at the input but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else if (row_in && !row_out) begin
      pending <= pending + 4'd1;
    end else if (row_out && !row_in) begin
      pending <= pending - 4'd1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_no_invented_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 4'd0)
    else $error("result without a pending row end");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd5)
    else $error("more rows in flight than the pipeline can hold");

endmodule

bind row_euclidean_norm rwn_checker u_rwn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
